// ===== rtl/core/bmci_pkg.sv =====
// Shared types, constants and helpers for the batch-means confidence interval core.
// Used by bmci_ctrl, bmci_dp, the top level and bmci_chk.
package bmci_pkg;

  localparam int NUM_STATS_DEF   = 16;
  localparam int BATCH_DEPTH_DEF = 64;

  localparam logic [15:0] BSIZE_RST = 16'd2;
  localparam logic [16:0] CI_Z_Q16  = 17'd128451;  // 1.96 in Q16.16

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 1;

  typedef enum logic [1:0] {
    DIV_CLOSE  = 2'd0,
    DIV_MU     = 2'd1,
    DIV_VAR    = 2'd2,
    DIV_MARGIN = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     st_rd;
    logic     st_load;
    logic     add_upd;
    logic     close_fin;
    logic     st_wr;
    logic     idx_clr;
    logic     pass_go;
    logic     pass_var;
    logic     div_go;
    div_sel_t div_sel;
    logic     mu_fin;
    logic     sq_go;
    logic     sq_rn;
    logic     sd_fin;
    logic     rn_fin;
    logic     mg_fin;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic stat_ok;
    logic need_close;
    logic n_zero;
    logic pass_done;
    logic div_done;
    logic sq_done;
    logic out_busy;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/bmci_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmci_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                      wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bmci_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module bmci_div #(
  parameter int DW = 70,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] qd;
  logic [VW-1:0] dv;
  logic [VW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem, qd[DW-1]};
  assign fits   = rem_sh >= {1'b0, dv};
  assign quot   = qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      qd  <= dividend;
      dv  <= divisor;
    end else if (busy) begin
      rem <= fits ? VW'(rem_sh - {1'b0, dv}) : rem_sh[VW-1:0];
      qd  <= {qd[DW-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/bmci_sqrt.sv =====
// Digit-by-digit integer square root: 64-bit radicand, 32-bit floor root,
// two radicand bits per cycle. No dependencies.
module bmci_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rad;
  logic [34:0] rem;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        fits;

  assign rem_sh = {rem[32:0], rad[63:62]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[61:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[30:0], fits};
    end
  end

endmodule

// ===== rtl/core/bmci_ctrl.sv =====
// Sequencer for the confidence interval core, uses bmci_pkg: walks each word
// through lookup, update, a due batch close and, for a query, the query passes.
module bmci_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           cfg_ready,
  input  bmci_pkg::sts_t sts,
  output bmci_pkg::cmd_t cmd
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_RD    = 16'h0002,
    S_LD    = 16'h0004,
    S_UPD   = 16'h0008,
    S_CHK   = 16'h0010,
    S_CDIV  = 16'h0020,
    S_WB    = 16'h0040,
    S_SUM   = 16'h0080,
    S_MUDIV = 16'h0100,
    S_VAR   = 16'h0200,
    S_VDIV  = 16'h0400,
    S_SDW   = 16'h0800,
    S_RNW   = 16'h1000,
    S_MGO   = 16'h2000,
    S_MDIV  = 16'h4000,
    S_RES   = 16'h8000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = bmci_pkg::DIV_CLOSE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        if (!sts.stat_ok) begin
          state_next = sts.is_query ? S_RES : S_IDLE;
        end else begin
          cmd.st_rd  = 1'b1;
          state_next = S_LD;
        end
      end
      S_LD: begin
        cmd.st_load = 1'b1;
        state_next  = S_UPD;
      end
      S_UPD: begin
        cmd.add_upd = !sts.is_query;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (sts.need_close) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = bmci_pkg::DIV_CLOSE;
          state_next  = S_CDIV;
        end else begin
          state_next = S_WB;
        end
      end
      S_CDIV: begin
        if (sts.div_done) begin
          cmd.close_fin = 1'b1;
          state_next    = S_WB;
        end
      end
      S_WB: begin
        cmd.st_wr   = 1'b1;
        cmd.idx_clr = 1'b1;
        if (!sts.is_query) state_next = S_IDLE;
        else if (sts.n_zero) state_next = S_RES;
        else state_next = S_SUM;
      end
      S_SUM: begin
        cmd.pass_go = 1'b1;
        if (sts.pass_done) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = bmci_pkg::DIV_MU;
          state_next  = S_MUDIV;
        end
      end
      S_MUDIV: begin
        if (sts.div_done) begin
          cmd.mu_fin  = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_VAR;
        end
      end
      S_VAR: begin
        cmd.pass_go  = 1'b1;
        cmd.pass_var = 1'b1;
        if (sts.pass_done) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = bmci_pkg::DIV_VAR;
          state_next  = S_VDIV;
        end
      end
      S_VDIV: begin
        if (sts.div_done) begin
          cmd.sq_go  = 1'b1;
          state_next = S_SDW;
        end
      end
      S_SDW: begin
        if (sts.sq_done) begin
          cmd.sd_fin = 1'b1;
          cmd.sq_go  = 1'b1;
          cmd.sq_rn  = 1'b1;
          state_next = S_RNW;
        end
      end
      S_RNW: begin
        if (sts.sq_done) begin
          cmd.rn_fin = 1'b1;
          state_next = S_MGO;
        end
      end
      S_MGO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = bmci_pkg::DIV_MARGIN;
        state_next  = S_MDIV;
      end
      S_MDIV: begin
        if (sts.div_done) begin
          cmd.mg_fin = 1'b1;
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bmci_dp.sv =====
// Datapath: per-statistic state RAM, batch store RAM, shared divider and
// square root, accumulators and the result register. Uses bmci_pkg,
// bmci_ram, bmci_div and bmci_sqrt.
module bmci_dp #(
  parameter int NUM_STATS   = bmci_pkg::NUM_STATS_DEF,
  parameter int BATCH_DEPTH = bmci_pkg::BATCH_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bmci_pkg::cmd_t     cmd,
  output bmci_pkg::sts_t     sts,
  input  logic               in_kind,
  input  logic [3:0]         in_stat_id,
  input  logic               in_stat_type,
  input  logic [31:0]        in_time_ticks,
  input  logic signed [31:0] in_sample_value,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] ci_low,
  output logic signed [31:0] ci_high,
  output logic signed [31:0] center,
  output logic [6:0]         batches_held,
  output logic               batches_dropped
);

  localparam int SW = (NUM_STATS > 1) ? $clog2(NUM_STATS) : 1;
  localparam int FW = $clog2(BATCH_DEPTH + 1);
  localparam int TW = 32 + FW + 1;
  localparam int AW = 64 + FW;
  localparam int RW = 32 + 64 + 32 + 1 + FW + 1;
  localparam int NA = NUM_STATS * BATCH_DEPTH;
  localparam int MA = (NA > 1) ? $clog2(NA) : 1;

  // captured word
  logic               q_kind, q_type;
  logic [3:0]         q_stat;
  logic [31:0]        q_time;
  logic signed [31:0] q_sample;
  logic [15:0]        bsize;

  // working copy of the addressed statistic
  logic [31:0]        w_count;
  logic signed [63:0] w_sum;
  logic [31:0]        w_start;
  logic               w_kind;
  logic [FW-1:0]      w_fill;
  logic               w_drop;

  logic [NUM_STATS-1:0] st_vld;
  logic                 row_vld;
  logic [SW-1:0]        sidx;
  logic [RW-1:0]        row_rd, row_wr;
  logic                 stat_ok;

  assign sidx    = SW'(q_stat);
  assign stat_ok = 32'(q_stat) < NUM_STATS;
  assign row_wr  = {w_drop, w_fill, w_kind, w_start, w_sum, w_count};

  bmci_ram #(.W(RW), .D(NUM_STATS)) u_stat_ram (
    .clk   (clk),
    .we    (cmd.st_wr),
    .waddr (sidx),
    .wdata (row_wr),
    .raddr (sidx),
    .rdata (row_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
      bsize  <= bmci_pkg::BSIZE_RST;
    end else begin
      if (cmd.st_wr) st_vld[sidx] <= 1'b1;
      if (cfg_we) bsize <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_kind   <= in_kind;
      q_stat   <= in_stat_id;
      q_type   <= in_stat_type;
      q_time   <= in_time_ticks;
      q_sample <= in_sample_value;
    end
    if (cmd.st_rd) row_vld <= st_vld[sidx];
  end

  // saturating add of the sample into the open sum
  logic signed [63:0] sext, sum_raw, sum_sat;
  logic               sum_ovf;
  logic [31:0]        bs_eff;

  assign sext    = 64'(q_sample);
  assign sum_raw = w_sum + sext;
  assign sum_ovf = (w_sum[63] == sext[63]) && (sum_raw[63] != w_sum[63]);
  assign sum_sat = !sum_ovf ? sum_raw :
                   (w_sum[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF);
  assign bs_eff  = (bsize == 16'd0) ? 32'd1 : 32'(bsize);

  // shared divider
  logic               div_done;
  logic [AW-1:0]      div_q, div_a;
  logic [31:0]        div_b;
  logic               div_neg, dneg;
  logic [63:0]        sum_mag;
  logic signed [TW-1:0] total;
  logic [TW-1:0]      tot_mag;
  logic [AW-1:0]      acc;
  logic [48:0]        prod;
  logic [31:0]        rn, sd;

  assign sum_mag = w_sum[63] ? 64'(-w_sum) : 64'(w_sum);
  assign tot_mag = total[TW-1] ? TW'(-total) : TW'(total);

  always_comb begin
    div_a   = AW'(sum_mag);
    div_b   = w_kind ? (q_time - w_start) : w_count;
    div_neg = w_sum[63];
    case (cmd.div_sel)
      bmci_pkg::DIV_CLOSE: begin
        div_a   = AW'(sum_mag);
        div_b   = w_kind ? (q_time - w_start) : w_count;
        div_neg = w_sum[63];
      end
      bmci_pkg::DIV_MU: begin
        div_a   = AW'(tot_mag);
        div_b   = 32'(w_fill);
        div_neg = total[TW-1];
      end
      bmci_pkg::DIV_VAR: begin
        div_a   = acc;
        div_b   = 32'(w_fill);
        div_neg = 1'b0;
      end
      bmci_pkg::DIV_MARGIN: begin
        div_a   = AW'(prod);
        div_b   = rn;
        div_neg = 1'b0;
      end
      default: begin
        div_a   = acc;
        div_b   = 32'(w_fill);
        div_neg = 1'b0;
      end
    endcase
  end

  bmci_div #(.DW(AW), .VW(32)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_go) dneg <= div_neg;
  end

  // signed quotient saturated to 32 bits
  logic               q_big_pos, q_big_neg;
  logic signed [31:0] close_val;

  assign q_big_pos = |div_q[AW-1:31];
  assign q_big_neg = (|div_q[AW-1:32]) || (div_q[31] && (|div_q[30:0]));
  always_comb begin
    if (dneg) close_val = q_big_neg ? 32'sh80000000 : 32'(-div_q[31:0]);
    else close_val = q_big_pos ? 32'sh7FFFFFFF : div_q[31:0];
  end

  // batch store
  logic [FW-1:0]      idx;
  logic               room, st_we, issue;
  logic [MA-1:0]      st_waddr, st_raddr;
  logic signed [31:0] x;

  assign room     = 32'(w_fill) < BATCH_DEPTH;
  assign st_we    = cmd.close_fin && room;
  assign st_waddr = MA'(32'(sidx) * BATCH_DEPTH + 32'(w_fill));
  assign st_raddr = MA'(32'(sidx) * BATCH_DEPTH + 32'(idx));
  assign issue    = cmd.pass_go && (idx != w_fill);

  bmci_ram #(.W(32), .D(NA)) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (close_val),
    .raddr (st_raddr),
    .rdata (x)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.st_load) begin
      if (row_vld) begin
        {w_drop, w_fill, w_kind, w_start, w_sum, w_count} <= row_rd;
      end else begin
        w_drop  <= 1'b0;
        w_fill  <= '0;
        w_kind  <= 1'b0;
        w_start <= row_rd[127:96];
        w_sum   <= '0;
        w_count <= '0;
      end
    end else if (cmd.add_upd) begin
      if (w_count == 32'd0) w_start <= q_time;
      w_sum  <= sum_sat;
      w_kind <= q_type;
      if (w_count != 32'hFFFFFFFF) w_count <= w_count + 32'd1;
    end else if (cmd.close_fin) begin
      if (room) w_fill <= w_fill + 1'b1;
      else w_drop <= 1'b1;
      w_count <= '0;
      w_sum   <= '0;
    end
  end

  // accumulation passes over the stored batch values
  logic               p1, p2, p3, pvar;
  logic signed [31:0] mu;
  logic signed [32:0] d;
  logic [31:0]        ad;
  logic [63:0]        sq;

  assign ad = d[32] ? 32'(-d) : d[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
    end else if (cmd.idx_clr) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
    end else begin
      p1 <= issue;
      p2 <= p1 && pvar;
      p3 <= p2;
    end
  end

  always_ff @(posedge clk) begin
    pvar <= cmd.pass_var;
    if (cmd.idx_clr) begin
      idx   <= '0;
      total <= '0;
      acc   <= '0;
    end else begin
      if (issue) idx <= idx + 1'b1;
      if (p1 && !pvar) total <= total + TW'(x);
      if (p3) acc <= acc + AW'(sq);
    end
    d  <= 33'(x) - 33'(mu);
    sq <= 64'(ad) * 64'(ad);
    if (cmd.mu_fin) mu <= dneg ? 32'(-div_q[31:0]) : div_q[31:0];
  end

  // square roots and margin
  logic        sq_done;
  logic [31:0] sq_root;
  logic [33:0] margin;

  bmci_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.sq_go),
    .radicand (cmd.sq_rn ? (64'(w_fill) << 32) : div_q[63:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.sd_fin) sd <= sq_root;
    if (cmd.rn_fin) begin
      rn   <= sq_root;
      prod <= 49'(sd) * 49'(bmci_pkg::CI_Z_Q16);
    end
    if (cmd.mg_fin) margin <= div_q[33:0];
  end

  // result register
  logic               blank;
  logic signed [35:0] mu36, mg36, lo36, hi36;

  assign blank = !stat_ok || (w_fill == '0);
  assign mu36  = 36'(mu);
  assign mg36  = $signed({2'b00, margin});
  assign lo36  = mu36 - mg36;
  assign hi36  = mu36 + mg36;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      ci_low          <= blank ? '0 : bmci_pkg::sat32(lo36);
      ci_high         <= blank ? '0 : bmci_pkg::sat32(hi36);
      center          <= blank ? '0 : mu;
      batches_held    <= stat_ok ? 7'(w_fill) : '0;
      batches_dropped <= stat_ok && w_drop;
    end
  end

  always_comb begin
    sts.is_query   = (q_kind == bmci_pkg::KIND_QUERY);
    sts.stat_ok    = stat_ok;
    sts.need_close = (w_count != 32'd0) && (q_time > w_start) &&
                     ((q_kind == bmci_pkg::KIND_QUERY) || (w_count >= bs_eff));
    sts.n_zero     = (w_fill == '0);
    sts.pass_done  = (idx == w_fill) && !p1 && !p2 && !p3;
    sts.div_done   = div_done;
    sts.sq_done    = sq_done;
    sts.out_busy   = res_valid && !res_ready;
  end

endmodule

// ===== rtl/core/batch_means_confidence_interval_core.sv =====
// Top level of the batch-means confidence interval core.
// Uses bmci_pkg, bmci_ctrl and bmci_dp.
//
//  channel  | direction | word
//  ---------+-----------+-----------------------------------------------
//  s_*      | in        | add sample or query for one statistic
//  m_*      | out       | one interval per query
//  cfg_*    | in        | batch_size
//
// An add or a query that closes a batch runs the bit-serial divider once to
// close it. A query with n stored batches, n above zero, then makes two passes
// over them, runs the divider three times and takes two 32-step square roots.
// rst is synchronous and clears control state and per-statistic valid bits.
// A finished result waits in the output register; only a further query stalls
// on it, at its last step.
module batch_means_confidence_interval_core #(
  parameter int NUM_STATS   = bmci_pkg::NUM_STATS_DEF,
  parameter int BATCH_DEPTH = bmci_pkg::BATCH_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // stat_id[3:0], time_ticks[35:4], sample_value[67:36], zero pad
  input  logic [bmci_pkg::IN_DATA_W-1:0]     s_tdata,
  // kind[0], stat_type[1]
  input  logic [bmci_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // ci_low[31:0], ci_high[63:32], center[95:64], batches_held[102:96], zero pad
  output logic [bmci_pkg::OUT_DATA_W-1:0]    m_tdata,
  // batches_dropped[0]
  output logic [bmci_pkg::OUT_USER_W-1:0]    m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [15:0]                        cfg_data
);

  bmci_pkg::cmd_t cmd;
  bmci_pkg::sts_t sts;

  logic signed [31:0] ci_low, ci_high, center;
  logic [6:0]         batches_held;
  logic               batches_dropped;

  bmci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmci_dp #(
    .NUM_STATS   (NUM_STATS),
    .BATCH_DEPTH (BATCH_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (s_tuser[0]),
    .in_stat_id      (s_tdata[3:0]),
    .in_stat_type    (s_tuser[1]),
    .in_time_ticks   (s_tdata[35:4]),
    .in_sample_value (s_tdata[67:36]),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .ci_low          (ci_low),
    .ci_high         (ci_high),
    .center          (center),
    .batches_held    (batches_held),
    .batches_dropped (batches_dropped)
  );

  assign m_tdata = {1'b0, batches_held, center, ci_high, ci_low};
  assign m_tuser = batches_dropped;

endmodule

// ===== rtl/core/bmci_chk.sv =====
// Port-level checks for the confidence interval core, bound to the top level.
// Uses bmci_pkg for port widths.
module bmci_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bmci_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [bmci_pkg::OUT_USER_W-1:0] m_tuser,
  input logic                            cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !cfg_ready)
    else $error("new word taken while one is in work");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[102:96] == 7'd0) |->
      (m_tdata[31:0] == 32'd0) && (m_tdata[63:32] == 32'd0) && (m_tdata[95:64] == 32'd0))
    else $error("interval not zero with no batches held");

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(m_tdata[95:64])) &&
                 ($signed(m_tdata[95:64]) <= $signed(m_tdata[63:32])))
    else $error("bounds do not enclose the centre");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind batch_means_confidence_interval_core bmci_chk u_bmci_chk (.*);
